[src/sic_pkg.sv]
// ----------------------------------------------------------------------------
// sic_pkg: shared types and widths for the segment intersection classifier
// Coordinate, cross-product and divider widths plus the request and result structs.
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_W      = 16;
  localparam int PT_W       = 32;

  localparam int DIFF_W  = COORD_BITS + 1;      // difference of two coordinates
  localparam int PROD_W  = 2 * DIFF_W;          // product of two differences
  localparam int CROSS_W = PROD_W + 1;          // cross product
  localparam int MAG_W   = CROSS_W - 1;         // magnitude of a cross product
  localparam int SUM_W   = MAG_W + 1;           // |d1| + |d2|
  localparam int E_W     = DIFF_W;              // magnitude of d - c
  localparam int Q_W     = E_W + FRAC_BITS;     // quotient bits
  localparam int N_W     = MAG_W + E_W + FRAC_BITS;
  localparam int TOT_W   = ((COORD_BITS + FRAC_BITS > Q_W) ?
                            COORD_BITS + FRAC_BITS : Q_W) + 2;

  typedef enum logic [1:0] {
    REL_SEPARATE = 2'd0,
    REL_CROSS    = 2'd1,
    REL_OVERLAP  = 2'd2
  } rel_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] d_x;
    logic signed [COORD_BITS-1:0] d_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             relation;
    logic                   point_valid;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
  } out_item_t;

  // one axis of work handed from the front end to a divider
  typedef struct packed {
    logic                         v;
    rel_t                         rel;
    logic signed [COORD_BITS-1:0] c;
    logic                         neg;
    logic [SUM_W-1:0]             s;
    logic [N_W-1:0]               n;
  } div_req_t;

  typedef struct packed {
    logic                   v;
    rel_t                   rel;
    logic signed [PT_W-1:0] pt;
  } div_rsp_t;

  function automatic logic signed [DIFF_W-1:0] sdiff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    sdiff = DIFF_W'($signed({a[COORD_BITS-1], a})) - DIFF_W'($signed({b[COORD_BITS-1], b}));
  endfunction

endpackage

[src/sic_front.sv]
// ----------------------------------------------------------------------------
// sic_front: box test, cross products and divider operands
// Five register stages: differences, products, crosses, signs, numerators.
// ----------------------------------------------------------------------------
module sic_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  sic_pkg::in_item_t      in_data,
  input  logic [sic_pkg::TOL_W-1:0] tol,
  output sic_pkg::div_req_t      req_x,
  output sic_pkg::div_req_t      req_y
);
  import sic_pkg::*;

  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] crs_t;

  // stage 1
  logic v1_r, v1_nxt, rej1_r, rej1_nxt;
  diff_t abx1_r, aby1_r, cbx1_r, cby1_r, dbx1_r, dby1_r;
  diff_t cdx1_r, cdy1_r, adx1_r, ady1_r, bdx1_r, bdy1_r, ex1_r, ey1_r;
  logic signed [COORD_BITS-1:0] cx1_r, cy1_r;
  // stage 2
  logic v2_r, rej2_r;
  prod_t p2_r [8];
  diff_t ex2_r, ey2_r;
  logic signed [COORD_BITS-1:0] cx2_r, cy2_r;
  // stage 3
  logic v3_r, rej3_r;
  crs_t d1_r, d2_r, e1_r, e2_r;
  diff_t ex3_r, ey3_r;
  logic signed [COORD_BITS-1:0] cx3_r, cy3_r;
  // stage 4
  logic v4_r;
  rel_t rel4_r, rel4_nxt;
  logic [MAG_W-1:0] m1_r;
  logic [SUM_W-1:0] s4_r;
  diff_t ex4_r, ey4_r;
  logic signed [COORD_BITS-1:0] cx4_r, cy4_r;
  // stage 5
  div_req_t rx_r, ry_r;

  logic signed [COORD_BITS-1:0] min_ab_x, max_ab_x, min_cd_x, max_cd_x;
  logic signed [COORD_BITS-1:0] min_ab_y, max_ab_y, min_cd_y, max_cd_y;
  logic signed [DIFF_W:0] tol_s;
  logic [MAG_W-1:0] m1_nxt, m2_nxt;
  logic [E_W-1:0] ex_mag, ey_mag;
  logic [MAG_W+E_W-1:0] nm_x, nm_y;

  function automatic logic [MAG_W-1:0] cmag(input crs_t v);
    crs_t t;
    t = v[CROSS_W-1] ? -v : v;
    cmag = t[MAG_W-1:0];
  endfunction

  function automatic logic [E_W-1:0] emag(input diff_t v);
    diff_t t;
    t = v[DIFF_W-1] ? -v : v;
    emag = t;
  endfunction

  function automatic logic signed [DIFF_W:0] ext(input diff_t v);
    ext = {v[DIFF_W-1], v};
  endfunction

  always_comb begin
    min_ab_x = (in_data.a_x < in_data.b_x) ? in_data.a_x : in_data.b_x;
    max_ab_x = (in_data.a_x > in_data.b_x) ? in_data.a_x : in_data.b_x;
    min_cd_x = (in_data.c_x < in_data.d_x) ? in_data.c_x : in_data.d_x;
    max_cd_x = (in_data.c_x > in_data.d_x) ? in_data.c_x : in_data.d_x;
    min_ab_y = (in_data.a_y < in_data.b_y) ? in_data.a_y : in_data.b_y;
    max_ab_y = (in_data.a_y > in_data.b_y) ? in_data.a_y : in_data.b_y;
    min_cd_y = (in_data.c_y < in_data.d_y) ? in_data.c_y : in_data.d_y;
    max_cd_y = (in_data.c_y > in_data.d_y) ? in_data.c_y : in_data.d_y;
    tol_s    = $signed({{(DIFF_W + 1 - TOL_W){1'b0}}, tol});
    v1_nxt   = in_valid;
    rej1_nxt = (ext(sdiff(min_cd_x, max_ab_x)) > tol_s) ||
               (ext(sdiff(min_ab_x, max_cd_x)) > tol_s) ||
               (ext(sdiff(min_cd_y, max_ab_y)) > tol_s) ||
               (ext(sdiff(min_ab_y, max_cd_y)) > tol_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= v1_nxt; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  // stage 1: coordinate differences
  always_ff @(posedge clk) begin
    if (en) begin
      rej1_r <= rej1_nxt;
      abx1_r <= sdiff(in_data.a_x, in_data.b_x); aby1_r <= sdiff(in_data.a_y, in_data.b_y);
      cbx1_r <= sdiff(in_data.c_x, in_data.b_x); cby1_r <= sdiff(in_data.c_y, in_data.b_y);
      dbx1_r <= sdiff(in_data.d_x, in_data.b_x); dby1_r <= sdiff(in_data.d_y, in_data.b_y);
      cdx1_r <= sdiff(in_data.c_x, in_data.d_x); cdy1_r <= sdiff(in_data.c_y, in_data.d_y);
      adx1_r <= sdiff(in_data.a_x, in_data.d_x); ady1_r <= sdiff(in_data.a_y, in_data.d_y);
      bdx1_r <= sdiff(in_data.b_x, in_data.d_x); bdy1_r <= sdiff(in_data.b_y, in_data.d_y);
      ex1_r  <= sdiff(in_data.d_x, in_data.c_x); ey1_r  <= sdiff(in_data.d_y, in_data.c_y);
      cx1_r  <= in_data.c_x; cy1_r <= in_data.c_y;
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (en) begin
      rej2_r <= rej1_r;
      p2_r[0] <= abx1_r * cby1_r; p2_r[1] <= aby1_r * cbx1_r;
      p2_r[2] <= abx1_r * dby1_r; p2_r[3] <= aby1_r * dbx1_r;
      p2_r[4] <= cdx1_r * ady1_r; p2_r[5] <= cdy1_r * adx1_r;
      p2_r[6] <= cdx1_r * bdy1_r; p2_r[7] <= cdy1_r * bdx1_r;
      ex2_r <= ex1_r; ey2_r <= ey1_r; cx2_r <= cx1_r; cy2_r <= cy1_r;
    end
  end

  // stage 3: cross products
  always_ff @(posedge clk) begin
    if (en) begin
      rej3_r <= rej2_r;
      d1_r <= crs_t'(p2_r[0]) - crs_t'(p2_r[1]);
      d2_r <= crs_t'(p2_r[2]) - crs_t'(p2_r[3]);
      e1_r <= crs_t'(p2_r[4]) - crs_t'(p2_r[5]);
      e2_r <= crs_t'(p2_r[6]) - crs_t'(p2_r[7]);
      ex3_r <= ex2_r; ey3_r <= ey2_r; cx3_r <= cx2_r; cy3_r <= cy2_r;
    end
  end

  // stage 4: classify by signs
  always_comb begin
    logic d1z, d2z, e1z, e2z, pd_pos, pe_pos, pd_neg, pe_neg;
    d1z = (d1_r == '0); d2z = (d2_r == '0);
    e1z = (e1_r == '0); e2z = (e2_r == '0);
    pd_pos = !d1z && !d2z && (d1_r[CROSS_W-1] == d2_r[CROSS_W-1]);
    pd_neg = !d1z && !d2z && (d1_r[CROSS_W-1] != d2_r[CROSS_W-1]);
    pe_pos = !e1z && !e2z && (e1_r[CROSS_W-1] == e2_r[CROSS_W-1]);
    pe_neg = !e1z && !e2z && (e1_r[CROSS_W-1] != e2_r[CROSS_W-1]);
    m1_nxt = cmag(d1_r);
    m2_nxt = cmag(d2_r);
    priority if (rej3_r || pd_pos || pe_pos) rel4_nxt = REL_SEPARATE;
    else if (pd_neg || pe_neg)                rel4_nxt = REL_CROSS;
    else                                      rel4_nxt = REL_OVERLAP;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rel4_r <= rel4_nxt;
      m1_r   <= m1_nxt;
      s4_r   <= {1'b0, m1_nxt} + {1'b0, m2_nxt};
      ex4_r <= ex3_r; ey4_r <= ey3_r; cx4_r <= cx3_r; cy4_r <= cy3_r;
    end
  end

  // stage 5: numerators |d1| * |e| scaled by the fraction bits
  assign ex_mag = emag(ex4_r);
  assign ey_mag = emag(ey4_r);
  assign nm_x   = m1_r * ex_mag;
  assign nm_y   = m1_r * ey_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r.v <= 1'b0; ry_r.v <= 1'b0;
    end else if (en) begin
      rx_r.v   <= v4_r;   ry_r.v   <= v4_r;
      rx_r.rel <= rel4_r; ry_r.rel <= rel4_r;
      rx_r.c   <= cx4_r;  ry_r.c   <= cy4_r;
      rx_r.neg <= ex4_r[DIFF_W-1]; ry_r.neg <= ey4_r[DIFF_W-1];
      rx_r.s   <= s4_r;   ry_r.s   <= s4_r;
      rx_r.n   <= {nm_x, {FRAC_BITS{1'b0}}};
      ry_r.n   <= {nm_y, {FRAC_BITS{1'b0}}};
    end
  end

  assign req_x = rx_r;
  assign req_y = ry_r;

endmodule

[src/sic_div.sv]
// ----------------------------------------------------------------------------
// sic_div: pipelined restoring divider for one axis of the crossing point
// One quotient bit per stage, then floor correction, offset and saturation.
// ----------------------------------------------------------------------------
module sic_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  sic_pkg::div_req_t req,
  output sic_pkg::div_rsp_t rsp
);
  import sic_pkg::*;

  typedef struct packed {
    logic                         v;
    rel_t                         rel;
    logic signed [COORD_BITS-1:0] c;
    logic                         neg;
    logic [SUM_W-1:0]             s;
    logic [Q_W-1:0]               nlo;
    logic [SUM_W-1:0]             r;
    logic [Q_W-1:0]               q;
  } dstage_t;

  dstage_t st_r [Q_W+1];
  dstage_t st_nxt [Q_W+1];
  div_rsp_t rsp_r, rsp_nxt;

  // the quotient stays below 2^Q_W, so the top bits start out below the divisor
  always_comb begin
    st_nxt[0].v   = req.v;
    st_nxt[0].rel = req.rel;
    st_nxt[0].c   = req.c;
    st_nxt[0].neg = req.neg;
    st_nxt[0].s   = req.s;
    st_nxt[0].nlo = req.n[Q_W-1:0];
    st_nxt[0].r   = SUM_W'(req.n[N_W-1:Q_W]);
    st_nxt[0].q   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r[0].v <= 1'b0;
    else if (en) st_r[0] <= st_nxt[0];
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    always_comb begin
      logic [SUM_W:0] sh;
      logic           ge;
      sh = {st_r[k-1].r, st_r[k-1].nlo[Q_W-1]};
      ge = (sh >= {1'b0, st_r[k-1].s});
      st_nxt[k]     = st_r[k-1];
      st_nxt[k].nlo = {st_r[k-1].nlo[Q_W-2:0], 1'b0};
      st_nxt[k].r   = ge ? SUM_W'(sh - {1'b0, st_r[k-1].s}) : sh[SUM_W-1:0];
      st_nxt[k].q   = {st_r[k-1].q[Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) st_r[k].v <= 1'b0;
      else if (en) st_r[k] <= st_nxt[k];
    end
  end

  // floor toward minus infinity, add the start coordinate, saturate; zero unless crossing
  always_comb begin
    logic [Q_W:0]            qq;
    logic signed [TOT_W-1:0] off, total;
    dstage_t                 f;
    f     = st_r[Q_W];
    qq    = {1'b0, f.q} + {{Q_W{1'b0}}, (f.neg && (f.r != '0))};
    off   = f.neg ? -$signed(TOT_W'(qq)) : $signed(TOT_W'(qq));
    total = ($signed(TOT_W'(f.c)) <<< FRAC_BITS) + off;
    rsp_nxt.v   = f.v;
    rsp_nxt.rel = f.rel;
    if (f.rel != REL_CROSS)
      rsp_nxt.pt = '0;
    else if (total > $signed(TOT_W'({1'b0, {(PT_W-1){1'b1}}})))
      rsp_nxt.pt = {1'b0, {(PT_W-1){1'b1}}};
    else if (total < -$signed(TOT_W'({1'b1, {(PT_W-1){1'b0}}})))
      rsp_nxt.pt = {1'b1, {(PT_W-1){1'b0}}};
    else
      rsp_nxt.pt = total[PT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rsp_r.v <= 1'b0;
    else if (en) rsp_r <= rsp_nxt;
  end

  assign rsp = rsp_r;

endmodule

[src/segment_intersection_classify.sv]
// ----------------------------------------------------------------------------
// segment_intersection_classify: classify two segments and find the crossing
// Box rejection with slack, exact cross-product signs, Q16.16 crossing point.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one request holding
//   the end points A, B, C and D. The output channel (out_valid/out_ready/
//   out_data) returns one result per request, in order: the relation and,
//   on a proper crossing, the floored point in signed Q16.16.
//   cfg_we/cfg_data writes the box slack; write it only while idle.
//   The pipeline holds five front stages (differences, products,
//   crosses, signs, numerators), a divider input stage, 33 divider stages
//   producing one quotient bit each, and one stage for the floor
//   correction and saturation.
//   Throughput is one request per cycle while out_ready is high.
//   A stall on the output freezes the whole pipeline: in_ready follows
//   !out_valid || out_ready, so nothing is lost or repeated, and the
//   pipeline keeps advancing while the output register is empty.
//   Reset clears every stage valid bit and sets the slack to zero.
// ----------------------------------------------------------------------------
module segment_intersection_classify (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sic_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sic_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [sic_pkg::TOL_W-1:0] cfg_data
);
  import sic_pkg::*;

  logic [TOL_W-1:0] tol_r;
  logic             en;
  div_req_t         req_x, req_y;
  div_rsp_t         rsp_x, rsp_y;

  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= '0;
    else if (cfg_we) tol_r <= cfg_data;
  end

  // advance unless a finished result is held up
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  sic_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .tol      (tol_r),
    .req_x    (req_x),
    .req_y    (req_y)
  );

  sic_div u_div_x (.clk(clk), .rst_n(rst_n), .en(en), .req(req_x), .rsp(rsp_x));
  sic_div u_div_y (.clk(clk), .rst_n(rst_n), .en(en), .req(req_y), .rsp(rsp_y));

  assign out_valid            = rsp_x.v && rsp_y.v;
  assign out_data.relation    = rsp_x.rel;
  assign out_data.point_valid = (rsp_x.rel == REL_CROSS);
  assign out_data.point_x     = rsp_x.pt;
  assign out_data.point_y     = rsp_y.pt;

endmodule

[src/sic_checker.sv]
// ----------------------------------------------------------------------------
// sic_checker: port-level checks for the segment intersection classifier
// Output hold under stall, in_ready against the stall rule, and result field consistency.
// ----------------------------------------------------------------------------
module sic_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sic_pkg::out_item_t out_data
);
  import sic_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_pv_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.point_valid == (out_data.relation == REL_CROSS))
    else $error("point_valid disagrees with relation");

  a_pt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.point_valid |-> out_data.point_x == '0 && out_data.point_y == '0)
    else $error("point not zero without a crossing");

  a_rel_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.relation == REL_SEPARATE || out_data.relation == REL_CROSS ||
                  out_data.relation == REL_OVERLAP)
    else $error("relation code out of range");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input taken while the pipeline is frozen");

endmodule

bind segment_intersection_classify sic_checker u_sic_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/sic_checker.sv]
// ----------------------------------------------------------------------------
// sic_tb_checker: result predictor and comparator for the segment classifier
// Watches both channels, works out the relation and crossing point of every
// accepted request and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
module sic_tb_checker
  import sic_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [TOL_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending
);

  out_item_t  expected_q[$];
  logic [TOL_W-1:0] slack;

  function automatic logic signed [PT_W-1:0] crossing_axis(
    input longint c, input longint d, input logic [127:0] m1, input logic [127:0] s
  );
    longint e;
    logic [127:0] n, q, r;
    longint qq, total;
    e = d - c;
    n = (m1 * 128'(e < 0 ? -e : e)) << FRAC_BITS;
    q = n / s;
    r = n % s;
    qq = (q > 128'(64'd1 << 62)) ? (64'sd1 <<< 62) : longint'(q[63:0]);
    if (e < 0 && r != 0) qq = qq + 1;
    total = c * (64'sd1 <<< FRAC_BITS) + (e < 0 ? -qq : qq);
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    return total[PT_W-1:0];
  endfunction

  function automatic out_item_t classify(input in_item_t p, input logic [TOL_W-1:0] tol);
    out_item_t r;
    longint ax, ay, bx, by, cx, cy, dx, dy, t, d1, d2, e1, e2;
    int pd, pe;
    logic [127:0] m1, m2;
    ax = p.a_x; ay = p.a_y; bx = p.b_x; by = p.b_y;
    cx = p.c_x; cy = p.c_y; dx = p.d_x; dy = p.d_y;
    t = tol;
    r = '0;
    if ((cx < dx ? cx : dx) - (ax > bx ? ax : bx) > t ||
        (ax < bx ? ax : bx) - (cx > dx ? cx : dx) > t ||
        (cy < dy ? cy : dy) - (ay > by ? ay : by) > t ||
        (ay < by ? ay : by) - (cy > dy ? cy : dy) > t)
      return r;
    // 17-bit differences give products well inside 64 bits
    d1 = (ax - bx) * (cy - by) - (ay - by) * (cx - bx);
    d2 = (ax - bx) * (dy - by) - (ay - by) * (dx - bx);
    e1 = (cx - dx) * (ay - dy) - (cy - dy) * (ax - dx);
    e2 = (cx - dx) * (by - dy) - (cy - dy) * (bx - dx);
    pd = ((d1 > 0) - (d1 < 0)) * ((d2 > 0) - (d2 < 0));
    pe = ((e1 > 0) - (e1 < 0)) * ((e2 > 0) - (e2 < 0));
    if (pd > 0 || pe > 0) return r;
    if (pd < 0 || pe < 0) begin
      m1 = 128'(d1 < 0 ? -d1 : d1);
      m2 = 128'(d2 < 0 ? -d2 : d2);
      r.relation = REL_CROSS;
      r.point_valid = 1'b1;
      r.point_x = crossing_axis(cx, dx, m1, m1 + m2);
      r.point_y = crossing_axis(cy, dy, m1, m1 + m2);
      return r;
    end
    r.relation = REL_OVERLAP;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      slack <= '0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) slack <= cfg_data;
      if (in_valid && in_ready) expected_q.push_back(classify(in_data, slack));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.relation !== out_data.relation ||
              want.point_valid !== out_data.point_valid ||
              want.point_x !== out_data.point_x ||
              want.point_y !== out_data.point_y) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression bench for segment_intersection_classify
// Directed corner requests, then random segment pairs biased toward crossing
// and touching geometry, under random stalls and several slack settings.
// ----------------------------------------------------------------------------
module tb;
  import sic_pkg::*;

  localparam int LATENCY = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_data = '0;
  int fail_count, pending;
  int cycles = 0;
  bit calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_intersection_classify DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  sic_tb_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_intersection_classify regression: fail");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= calm || ($urandom_range(99) >= 12);

  function automatic logic signed [15:0] near(input int base, input int spread);
    int v;
    v = base + $signed($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // valid stays high after the request; drop it only while idling
  task automatic send(input in_item_t p);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_and_set_slack(input logic [TOL_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t random_pair(input int mode);
    in_item_t p;
    int cxp, cyp, sp;
    p = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    sp = (mode == 1) ? 40 : 4000;
    cxp = $signed($urandom) % 30000;
    cyp = $signed($urandom) % 30000;
    case (mode)
      0: ;  // fully random coordinates
      1, 2: begin
        // short segments around one centre: crossing is likely
        p.a_x = near(cxp, sp); p.a_y = near(cyp, sp);
        p.b_x = near(cxp, sp); p.b_y = near(cyp, sp);
        p.c_x = near(cxp, sp); p.c_y = near(cyp, sp);
        p.d_x = near(cxp, sp); p.d_y = near(cyp, sp);
      end
      3: begin
        // shared end point, or collinear pieces
        p.a_x = near(cxp, 100); p.a_y = near(cyp, 100);
        p.b_x = near(cxp, 100); p.b_y = near(cyp, 100);
        if ($urandom_range(1)) begin
          p.c_x = p.b_x; p.c_y = p.b_y;
        end else begin
          p.c_x = p.a_x + (p.b_x - p.a_x) / 2; p.c_y = p.a_y + (p.b_y - p.a_y) / 2;
          p.d_x = p.b_x + (p.b_x - p.a_x) / 2; p.d_y = p.b_y + (p.b_y - p.a_y) / 2;
        end
      end
      default: begin
        // long diagonals across the full range
        p.a_x = near(-32768, 50); p.a_y = near(-32768, 50);
        p.b_x = near(32767, 50);  p.b_y = near(32767, 50);
        p.c_x = near(-32768, 50); p.c_y = near(32767, 50);
        p.d_x = near(32767, 50);  p.d_y = near(-32768, 50);
      end
    endcase
    return p;
  endfunction

  initial begin
    logic [TOL_W-1:0] slacks [5];
    in_item_t p;
    slacks = '{16'd0, 16'hFFFF, 16'd3, 16'd200, 16'd1};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, crossing, touching, collinear, degenerate, separate
    send('{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
           -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768});
    send('{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
           16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767});
    send('{16'sd0, 16'sd0, 16'sd4, 16'sd4, 16'sd0, 16'sd4, 16'sd4, 16'sd0});
    send('{16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd0, 16'sd1, 16'sd3, -16'sd1});
    send('{16'sd0, 16'sd0, 16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd5, 16'sd0});
    send('{16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd2, 16'sd0, 16'sd8, 16'sd0});
    send('{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5});
    send('{16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd10, 16'sd10, 16'sd12, 16'sd11});
    send('{16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd0, 16'sd1, 16'sd4, 16'sd1});
    send('{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send('{16'sd0, 16'sd0, 16'sd7, 16'sd3, 16'sd1, 16'sd5, 16'sd6, -16'sd2});
    send('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send('{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1});

    for (int ph = 0; ph < 5; ph++) begin
      drain_and_set_slack(slacks[ph]);
      calm = (ph == 2);
      for (int i = 0; i < 370; i++) begin
        p = random_pair($urandom_range(9) < 2 ? 0 : $urandom_range(1, 4));
        send(p);
        if (ph == 1 && i == 100) begin
          // hold off until every result is back
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && !out_valid)
      $display("segment_intersection_classify regression: pass");
    else
      $display("segment_intersection_classify regression: fail");
    $finish;
  end

endmodule
